[src/itoa_pkg.sv]
`timescale 1ns / 1ps
// Shared types, codes and constants for the integer-to-ASCII formatter.
// Used by itoa_div_unit and integer_to_ascii_formatter_top; depends on nothing.
package itoa_pkg;

	// Conversion modes as they arrive on the input item.
	localparam logic [2:0] MODE_OCT  = 3'd0;
	localparam logic [2:0] MODE_DEC  = 3'd1;
	localparam logic [2:0] MODE_HEXU = 3'd2;
	localparam logic [2:0] MODE_HEXL = 3'd3;
	localparam logic [2:0] MODE_SDEC = 3'd4;

	// Radix selection for the shared divide unit.
	typedef enum logic [1:0] {
		BASE_OCT,
		BASE_DEC,
		BASE_HEX
	} base_t;

	// Field width saturation and digit buffer sizing.
	localparam int MAX_WIDTH = 64;
	localparam int FW_W      = 7;
	localparam int DIG_MAX   = 12;
	localparam int DIG_W     = $clog2(DIG_MAX + 1);

	// Reciprocal of ten scaled by 2^35; exact quotient for every 32-bit value.
	localparam logic [31:0] RECIP_10 = 32'hCCCC_CCCD;
	localparam int          RECIP_SH = 35;

	// ASCII codes.
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_UPPER = 8'h41;
	localparam logic [7:0] CH_LOWER = 8'h61;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_SPACE = 8'h20;

	// Map a digit value to its ASCII character.
	function automatic logic [7:0] digit_char(input logic [3:0] d, input logic lower);
		logic [7:0] base_ch;
		base_ch = lower ? CH_LOWER : CH_UPPER;
		if (d < 4'd10) begin
			digit_char = CH_ZERO + {4'b0, d};
		end else begin
			digit_char = base_ch + {4'b0, d - 4'd10};
		end
	endfunction

endpackage

[src/itoa_div_unit.sv]
`timescale 1ns / 1ps
// Shared divide unit: quotient and remainder of a 32-bit value by 8, 10 or 16.
// One register stage; depends on itoa_pkg.
module itoa_div_unit (
	input  logic               clk,
	input  itoa_pkg::base_t    base,
	input  logic [31:0]        num,
	output logic [31:0]        quo,
	output logic [3:0]         rem
);

	logic [63:0] prod_q;
	logic [31:0] num_q;
	logic [31:0] q_dec;
	logic [31:0] back_dec;

	// Register the reciprocal product and the dividend.
	always_ff @(posedge clk) begin
		prod_q <= 64'(num) * 64'(itoa_pkg::RECIP_10);
		num_q  <= num;
	end

	// Decimal quotient from the product, remainder by shift-and-add back.
	assign q_dec    = 32'(prod_q[63:itoa_pkg::RECIP_SH]);
	assign back_dec = {q_dec[28:0], 3'b000} + {q_dec[30:0], 1'b0};

	always_comb begin
		unique case (base)
			itoa_pkg::BASE_OCT: begin
				quo = {3'b000, num_q[31:3]};
				rem = {1'b0, num_q[2:0]};
			end
			itoa_pkg::BASE_HEX: begin
				quo = {4'b0000, num_q[31:4]};
				rem = num_q[3:0];
			end
			default: begin
				quo = q_dec;
				rem = 4'((num_q - back_dec) & 32'hF);
			end
		endcase
	end

endmodule

[src/integer_to_ascii_formatter_top.sv]
`timescale 1ns / 1ps
// Top level of the integer-to-ASCII formatter: input sequencer, digit buffer
// and character output register. Depends on itoa_pkg and itoa_div_unit.

// Each input item is one 32-bit value converted printf style (%o, %u, %X, %x
// or %d) into a run of ASCII characters, one output item per character, with
// tlast on the final one. Leading spaces pad the run up to min_width (capped
// at 64), then comes any minus sign, then the digits. The block works on one
// item at a time: it accepts the item, extracts each digit in the shared
// divide unit (multiply stage, then digit write-back), closes the padding
// phase, then emits one character per cycle while the sink is ready. The last
// character may still wait in the output register while the next item is
// accepted.
module integer_to_ascii_formatter_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,   // mode[2:0], value[34:3], min_width[41:35], zeros
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,   // character[7:0]
	output logic        m_axis_tlast    // last
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_MUL  = 3'd1;
	localparam logic [2:0] S_DIG  = 3'd2;
	localparam logic [2:0] S_PAD  = 3'd3;
	localparam logic [2:0] S_SIGN = 3'd4;
	localparam logic [2:0] S_OUT  = 3'd5;

	localparam int W = itoa_pkg::FW_W;
	localparam int D = itoa_pkg::DIG_W;

	logic [2:0]        state_q;
	itoa_pkg::base_t   base_q;
	logic              lower_q;
	logic              neg_q;
	logic [31:0]       val_q;
	logic [W-1:0]      width_q;
	logic [D-1:0]      nd_q;
	logic [D-1:0]      idx_q;
	logic [W-1:0]      pad_q;
	logic [3:0]        digs_q [itoa_pkg::DIG_MAX];
	logic              out_valid_q;
	logic [7:0]        out_char_q;
	logic              out_last_q;

	logic              accept;
	logic              out_free;
	logic              out_load;
	logic [2:0]        in_mode;
	logic [31:0]       in_value;
	logic [W-1:0]      in_width;
	logic [31:0]       div_quo;
	logic [3:0]        div_rem;
	logic [D-1:0]      nd_next;
	logic [W-1:0]      need;
	logic              dig_done;

	// Unpack the input item.
	assign in_mode  = s_axis_tdata[2:0];
	assign in_value = s_axis_tdata[34:3];
	assign in_width = s_axis_tdata[41:35];

	assign s_axis_tready = (state_q == S_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign out_free      = !out_valid_q || m_axis_tready;

	// A pad, sign or digit character is loaded into the output register.
	assign out_load = out_free && (((state_q == S_PAD) && (pad_q != W'(0))) ||
		(state_q == S_SIGN) || (state_q == S_OUT));

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_char_q;
	assign m_axis_tlast  = out_last_q;

	// Shared divide unit, fed from the running value.
	itoa_div_unit u_div (
		.clk  (clk),
		.base (base_q),
		.num  (val_q),
		.quo  (div_quo),
		.rem  (div_rem)
	);

	// Digit count after this step and the characters needed before padding.
	assign nd_next  = nd_q + D'(1);
	assign need     = W'(nd_next) + W'(neg_q);
	assign dig_done = (div_quo == 32'd0) || (nd_next == D'(itoa_pkg::DIG_MAX));

	// Sequencer and control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					state_q <= S_DIG;
				end
				S_DIG: begin
					state_q <= dig_done ? S_PAD : S_MUL;
				end
				S_PAD: begin
					if (pad_q == W'(0)) begin
						state_q <= neg_q ? S_SIGN : S_OUT;
					end
				end
				S_SIGN: begin
					if (out_free) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_free && idx_q == D'(0)) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					nd_q    <= D'(0);
					neg_q   <= 1'b0;
					lower_q <= 1'b0;
					val_q   <= in_value;
					width_q <= (in_width > W'(itoa_pkg::MAX_WIDTH)) ?
						W'(itoa_pkg::MAX_WIDTH) : in_width;
					unique case (in_mode)
						itoa_pkg::MODE_OCT:  base_q <= itoa_pkg::BASE_OCT;
						itoa_pkg::MODE_HEXU: base_q <= itoa_pkg::BASE_HEX;
						itoa_pkg::MODE_HEXL: begin
							base_q  <= itoa_pkg::BASE_HEX;
							lower_q <= 1'b1;
						end
						itoa_pkg::MODE_SDEC: begin
							base_q <= itoa_pkg::BASE_DEC;
							if (in_value[31]) begin
								neg_q <= 1'b1;
								val_q <= 32'd0 - in_value;
							end
						end
						default: base_q <= itoa_pkg::BASE_DEC;
					endcase
				end
			end
			S_DIG: begin
				digs_q[nd_q] <= div_rem;
				nd_q         <= nd_next;
				val_q        <= div_quo;
				idx_q        <= nd_q;
				pad_q        <= (width_q > need) ? (width_q - need) : W'(0);
			end
			S_PAD: begin
				if (pad_q != W'(0) && out_free) begin
					out_char_q <= itoa_pkg::CH_SPACE;
					out_last_q <= 1'b0;
					pad_q      <= pad_q - W'(1);
				end
			end
			S_SIGN: begin
				if (out_free) begin
					out_char_q <= itoa_pkg::CH_MINUS;
					out_last_q <= 1'b0;
				end
			end
			S_OUT: begin
				if (out_free) begin
					out_char_q <= itoa_pkg::digit_char(digs_q[idx_q], lower_q);
					out_last_q <= (idx_q == D'(0));
					idx_q      <= idx_q - D'(1);
				end
			end
			default: begin
			end
		endcase
	end

`ifndef SYNTHESIS
	// An accepted item always starts the divide sequence.
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == S_MUL))
		else $error("accepted item did not start digit extraction");

	// A decimal remainder from the reciprocal unit is a valid digit.
	a_dec_digit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIG && base_q == itoa_pkg::BASE_DEC) |-> (div_rem <= 4'd9))
		else $error("decimal remainder out of range");

	// The final digit goes out flagged as the end of the run.
	a_last_digit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT && out_free && idx_q == D'(0)) |=>
		(m_axis_tvalid && m_axis_tlast && state_q == S_IDLE))
		else $error("final digit not marked last");

	// The digit buffer never overflows.
	a_nd_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIG) |-> (nd_q < D'(itoa_pkg::DIG_MAX)))
		else $error("digit buffer overflow");
`endif

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for integer_to_ascii_formatter_top: directed and random
// conversions checked character by character against a built-in predictor.
// Depends on itoa_pkg and the formatter RTL.

// One expected output character and its end-of-run flag.
typedef struct packed {
	logic [7:0] code;
	logic       is_last;
} ascii_char_t;

// Holds the characters each accepted value should produce and checks the stream.
class ascii_scoreboard;
	ascii_char_t pending_chars[$];
	int unsigned mismatches;

	function new();
		mismatches = 0;
	endfunction

	// Converts one accepted value the way printf would and queues its characters.
	function void note_item(input logic [2:0] mode, input logic [31:0] value,
		input logic [6:0] min_width);
		logic [31:0] radix;
		logic [31:0] mag;
		logic [31:0] digit;
		logic [7:0]  letter_base;
		logic [7:0]  digits[$];
		ascii_char_t item;
		bit          neg;
		int          width_sat;
		int          needed;
		int          i;

		radix = 32'd10;
		letter_base = itoa_pkg::CH_UPPER;
		neg = 1'b0;
		mag = value;
		width_sat = (min_width > itoa_pkg::MAX_WIDTH) ? itoa_pkg::MAX_WIDTH :
			int'(min_width);

		case (mode)
			itoa_pkg::MODE_OCT: begin
				radix = 32'd8;
			end
			itoa_pkg::MODE_HEXU: begin
				radix = 32'd16;
			end
			itoa_pkg::MODE_HEXL: begin
				radix = 32'd16;
				letter_base = itoa_pkg::CH_LOWER;
			end
			itoa_pkg::MODE_SDEC: begin
				if (value[31]) begin
					neg = 1'b1;
					mag = 32'd0 - value;
				end
			end
			default: begin
				// Unsigned decimal, which the unused codes fall back to as well.
				radix = 32'd10;
			end
		endcase

		// Digits are built least significant first, so each goes to the front.
		do begin
			digit = mag % radix;
			if (digit < 32'd10) begin
				digits.push_front(itoa_pkg::CH_ZERO + digit[7:0]);
			end else begin
				digits.push_front(letter_base + digit[7:0] - 8'd10);
			end
			mag = mag / radix;
		end while (mag != 32'd0);

		// Spaces first, then the sign, then the digits.
		needed = digits.size() + (neg ? 1 : 0);
		for (i = needed; i < width_sat; i++) begin
			item.code = itoa_pkg::CH_SPACE;
			item.is_last = 1'b0;
			pending_chars.push_back(item);
		end
		if (neg) begin
			item.code = itoa_pkg::CH_MINUS;
			item.is_last = 1'b0;
			pending_chars.push_back(item);
		end
		for (i = 0; i < digits.size(); i++) begin
			item.code = digits[i];
			item.is_last = (i == digits.size() - 1);
			pending_chars.push_back(item);
		end
	endfunction

	// Compares one received character with the oldest one outstanding.
	function void check_char(input logic [7:0] code, input logic is_last);
		ascii_char_t want;

		if (pending_chars.size() == 0) begin
			mismatches++;
			if (mismatches <= 10) begin
				$display("%0t: unexpected character 0x%02h last=%0b with nothing outstanding",
					$realtime, code, is_last);
			end
		end else begin
			want = pending_chars.pop_front();
			if (code !== want.code || is_last !== want.is_last) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("%0t: character expected 0x%02h got 0x%02h, last expected %0b got %0b",
						$realtime, want.code, code, want.is_last, is_last);
				end
			end
		end
	endfunction

	function int outstanding();
		return pending_chars.size();
	endfunction
endclass

module tb;

	// Unused mode codes; the block treats them as unsigned decimal.
	localparam logic [2:0] MODE_RSVD5 = 3'd5;
	localparam logic [2:0] MODE_RSVD6 = 3'd6;
	localparam logic [2:0] MODE_RSVD7 = 3'd7;

	localparam int RANDOM_PER_PHASE = 88;
	localparam int DRAIN_CYCLES     = 120;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [47:0] s_axis_tdata = '0;    // mode[2:0], value[34:3], min_width[41:35], zeros
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [7:0]  m_axis_tdata;         // character[7:0]
	logic        m_axis_tlast;

	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;

	ascii_scoreboard sb;

	integer_to_ascii_formatter_top i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	always #5 clk = ~clk;

	// Character sink: checks every accepted character and stalls at random.
	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready) begin
			sb.check_char(m_axis_tdata, m_axis_tlast);
		end
		m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Presents one value, with an optional idle gap first, and waits for it to be taken.
	task automatic send_value(input logic [2:0] mode, input logic [31:0] value,
		input logic [6:0] min_width);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {6'b0, min_width, value, mode};
		do begin
			@(posedge clk);
		end while (!s_axis_tready);
		sb.note_item(mode, value, min_width);
	endtask

	// Random value, mostly in the defined modes and with modest field widths.
	task automatic send_random_value();
		logic [2:0]  mode;
		logic [31:0] value;
		logic [6:0]  min_width;
		int unsigned pick;

		if ($urandom_range(9) == 0) begin
			mode = 3'($urandom_range(7, 5));
		end else begin
			mode = 3'($urandom_range(4, 0));
		end

		pick = $urandom_range(99);
		if (pick < 50) begin
			value = $urandom;
		end else if (pick < 70) begin
			value = $urandom_range(255);
		end else if (pick < 80) begin
			// Around the sign boundary and the top of the range.
			value = ($urandom_range(1) ? 32'h8000_0000 : 32'hFFFF_FFFF) ^ $urandom_range(15);
		end else begin
			value = 32'd1 << $urandom_range(31);
			if ($urandom_range(1)) begin
				value = value - 32'd1;
			end
		end

		pick = $urandom_range(99);
		if (pick < 60) begin
			min_width = 7'($urandom_range(12));
		end else if (pick < 85) begin
			min_width = 7'($urandom_range(24, 13));
		end else if (pick < 95) begin
			min_width = 7'($urandom_range(64, 25));
		end else begin
			min_width = 7'($urandom_range(127, 65));
		end

		send_value(mode, value, min_width);
	endtask

	initial begin
		int phase;
		int n;

		sb = new();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: zeros, extremes, every mode, padding and saturation.
		send_value(itoa_pkg::MODE_OCT,  32'h0000_0000, 7'd0);
		send_value(itoa_pkg::MODE_DEC,  32'h0000_0000, 7'd0);
		send_value(itoa_pkg::MODE_HEXU, 32'h0000_0000, 7'd1);
		send_value(itoa_pkg::MODE_SDEC, 32'h0000_0000, 7'd5);
		send_value(itoa_pkg::MODE_OCT,  32'hFFFF_FFFF, 7'd0);
		send_value(itoa_pkg::MODE_DEC,  32'hFFFF_FFFF, 7'd0);
		send_value(itoa_pkg::MODE_HEXU, 32'hFFFF_FFFF, 7'd0);
		send_value(itoa_pkg::MODE_HEXU, 32'hABCD_EF01, 7'd0);
		send_value(itoa_pkg::MODE_HEXL, 32'hABCD_EF89, 7'd12);
		send_value(itoa_pkg::MODE_SDEC, 32'h8000_0000, 7'd0);
		send_value(itoa_pkg::MODE_SDEC, 32'h8000_0000, 7'd20);
		send_value(itoa_pkg::MODE_SDEC, 32'hFFFF_FFFF, 7'd2);
		send_value(itoa_pkg::MODE_SDEC, 32'hFFFF_FFFF, 7'd3);
		send_value(itoa_pkg::MODE_SDEC, 32'h7FFF_FFFF, 7'd10);
		send_value(itoa_pkg::MODE_DEC,  32'd12345,     7'd3);
		send_value(itoa_pkg::MODE_DEC,  32'd1,         7'd64);
		send_value(itoa_pkg::MODE_HEXL, 32'h0000_0000, 7'd127);
		send_value(itoa_pkg::MODE_OCT,  32'd8,         7'd65);
		send_value(MODE_RSVD5,          32'd1234,      7'd6);
		send_value(MODE_RSVD6,          32'hFFFF_FFFF, 7'd0);
		send_value(MODE_RSVD7,          32'h8000_0000, 7'd11);
		send_value(itoa_pkg::MODE_SDEC, 32'd1,         7'd127);
		send_value(itoa_pkg::MODE_OCT,  32'o01234567,  7'd0);
		send_value(itoa_pkg::MODE_DEC,  32'd123456789, 7'd9);
		send_value(itoa_pkg::MODE_HEXU, 32'h0123_4567, 7'd8);

		// Random values under four flow-control regimes.
		for (phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct = 58;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 58;
				end
				default: begin
					send_idle_pct = 31;
					recv_stall_pct = 31;
				end
			endcase
			for (n = 0; n < RANDOM_PER_PHASE; n++) begin
				send_random_value();
			end
		end

		s_axis_tvalid <= 1'b0;
		while (sb.outstanding() != 0) begin
			@(posedge clk);
		end
		// Let any stray characters show up before deciding.
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (sb.mismatches == 0) begin
			$display("** integer_to_ascii_formatter_top: PASSED **");
		end else begin
			$display("** integer_to_ascii_formatter_top: FAILED **");
		end
		$finish;
	end

	// Watchdog against a hung handshake.
	initial begin
		#10ms;
		$display("** integer_to_ascii_formatter_top: FAILED **");
		$finish;
	end

endmodule

[sim.f]
src/itoa_pkg.sv
src/itoa_div_unit.sv
src/integer_to_ascii_formatter_top.sv
tb/sv/tb.sv
